FILE: sv/harmonic_angle_synthesizer_defines.svh
// Assertion macros shared by the harmonic angle synthesizer RTL
`ifndef HARMONIC_ANGLE_SYNTHESIZER_DEFINES_SVH
`define HARMONIC_ANGLE_SYNTHESIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define HAS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define HAS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/has_pkg.sv
// Types, constants and sine table function for the harmonic angle synthesizer
package has_pkg;

	localparam int DEFAULT_HARMONICS  = 3;
	localparam int DEFAULT_SINE_DEPTH = 1024;
	localparam int MAX_HARMONICS      = 3;

	localparam int PHASE_W      = 16;
	localparam int COEF_W       = 24;
	localparam int SINE_W       = 16;
	localparam int QMAG_W       = 15;
	localparam int PROD_W       = COEF_W + SINE_W;
	localparam int PAIR_W       = PROD_W + 1;
	localparam int ACC_W        = PROD_W + 2;
	localparam int ROUND_SHIFT  = 15;
	localparam int OUT_W        = 27;
	localparam int TDATA_IN_W   = 16;
	localparam int TDATA_OUT_W  = 32;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 24;

	localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEUTRAL  = 4'd0,
		REG_CONSTANT = 4'd1,
		REG_SIN1     = 4'd2,
		REG_SIN2     = 4'd3,
		REG_SIN3     = 4'd4,
		REG_COS1     = 4'd5,
		REG_COS2     = 4'd6,
		REG_COS3     = 4'd7
	} has_reg_e;

	typedef struct packed {
		logic signed [COEF_W-1:0]            neutral_position;
		logic signed [COEF_W-1:0]            constant_term;
		logic [MAX_HARMONICS-1:0][COEF_W-1:0] sin_coef;
		logic [MAX_HARMONICS-1:0][COEF_W-1:0] cos_coef;
	} has_cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} has_stage_en_t;

	// Quarter-wave sine magnitude of entry j out of a (1 << lg)-entry full-turn table.
	// Taylor series to x^9 in Q30 with truncated products, rounded to Q15.
	function automatic logic [QMAG_W-1:0] quarter_sine(input int unsigned j,
			input int unsigned lg);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		x  = ((64'(j) << 2) * HALF_PI_Q30) >> lg;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		v  = (s + 64'd16384) >> 15;
		if (v > 64'd32767)
			v = 64'd32767;
		return v[QMAG_W-1:0];
	endfunction

endpackage

FILE: sv/has_cfg_regs.sv
// Configuration register file: offset, constant term and harmonic coefficients
module has_cfg_regs import has_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output has_cfg_t              cfg
);

	has_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NEUTRAL:  cfg_q.neutral_position <= cfg_data;
				REG_CONSTANT: cfg_q.constant_term    <= cfg_data;
				REG_SIN1:     cfg_q.sin_coef[0]      <= cfg_data;
				REG_SIN2:     cfg_q.sin_coef[1]      <= cfg_data;
				REG_SIN3:     cfg_q.sin_coef[2]      <= cfg_data;
				REG_COS1:     cfg_q.cos_coef[0]      <= cfg_data;
				REG_COS2:     cfg_q.cos_coef[1]      <= cfg_data;
				REG_COS3:     cfg_q.cos_coef[2]      <= cfg_data;
				// drop writes past the register list
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/has_sine_lookup.sv
// Two-stage sine lookup: quadrant fold, then quarter-wave table read and sign
module has_sine_lookup import has_pkg::*; #(
	parameter int SINE_LG = $clog2(DEFAULT_SINE_DEPTH)
) (
	input  logic               clk,
	input  has_stage_en_t      stage_en,
	input  logic [PHASE_W-1:0] phase,
	output logic [SINE_W-1:0]  sine_s2
);

	localparam int QD = 1 << (SINE_LG - 2);

	logic [QMAG_W-1:0]  qtab [QD+1];
	logic [SINE_LG-1:0] idx;
	logic [1:0]         quad;
	logic [SINE_LG-3:0] low;
	logic [SINE_LG-2:0] fold;
	logic [SINE_LG-2:0] fold_s1;
	logic               neg_s1;
	logic [SINE_W-1:0]  mag;

	for (genvar gi = 0; gi <= QD; gi++) begin : g_tab
		assign qtab[gi] = quarter_sine(gi, SINE_LG);
	end

	assign idx  = phase[PHASE_W-1 -: SINE_LG];
	assign quad = idx[SINE_LG-1:SINE_LG-2];
	assign low  = idx[SINE_LG-3:0];
	// odd quadrants read the quarter wave backwards
	assign fold = quad[0] ? ((SINE_LG-1)'(QD) - {1'b0, low}) : {1'b0, low};
	assign mag  = {1'b0, qtab[fold_s1]};

	always_ff @(posedge clk) begin
		if (stage_en.s1) begin
			fold_s1 <= fold;
			neg_s1  <= quad[1];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en.s2)
			sine_s2 <= neg_s1 ? (SINE_W'(0) - mag) : mag;
	end

endmodule

FILE: sv/has_mac.sv
// Multiply sines by coefficients, sum in pairs, then total and round off the Q15 sine scaling
module has_mac import has_pkg::*; #(
	parameter int HARMONICS = DEFAULT_HARMONICS
) (
	input  logic                                    clk,
	input  has_stage_en_t                           stage_en,
	input  has_cfg_t                                cfg,
	input  logic [2*MAX_HARMONICS-1:0][SINE_W-1:0]  sine,
	output logic signed [OUT_W-1:0]                 sum_s5
);

	logic signed [PROD_W-1:0] prod_s3 [2*MAX_HARMONICS];
	logic signed [PAIR_W-1:0] pair_s4 [MAX_HARMONICS];
	logic signed [ACC_W-1:0]  total;

	for (genvar gk = 0; gk < MAX_HARMONICS; gk++) begin : g_harm
		if (gk < HARMONICS) begin : g_used
			always_ff @(posedge clk) begin
				if (stage_en.s3) begin
					prod_s3[gk] <= PROD_W'($signed(cfg.sin_coef[gk]))
						* PROD_W'($signed(sine[gk]));
					prod_s3[gk+MAX_HARMONICS] <= PROD_W'($signed(cfg.cos_coef[gk]))
						* PROD_W'($signed(sine[gk+MAX_HARMONICS]));
				end
			end
		end else begin : g_unused
			// harmonic above the configured count contributes nothing
			always_ff @(posedge clk) begin
				if (stage_en.s3) begin
					prod_s3[gk]               <= '0;
					prod_s3[gk+MAX_HARMONICS] <= '0;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (stage_en.s4)
				pair_s4[gk] <= PAIR_W'(prod_s3[gk]) + PAIR_W'(prod_s3[gk+MAX_HARMONICS]);
		end
	end

	// round half up, then floor by the arithmetic shift
	assign total = ACC_W'(pair_s4[0]) + ACC_W'(pair_s4[1]) + ACC_W'(pair_s4[2])
		+ ACC_W'(1 << (ROUND_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (stage_en.s5)
			sum_s5 <= total[ROUND_SHIFT +: OUT_W];
	end

endmodule

FILE: sv/harmonic_angle_synthesizer.sv
// Top level: three-harmonic Fourier series of an azimuth phase, six-stage pipeline
//
//   channel  group                                 payload
//   s_*      s_tvalid s_tready s_tdata[15:0]       azimuth_phase
//   m_*      m_tvalid m_tready m_tdata[31:0]       hinge_angle in [26:0]
//   cfg_*    cfg_valid cfg_ready cfg_index cfg_data register write
//
// One transaction per cycle from input to result while the output is not stalled.
// Stages: fold phases, sine table read, multiply, pair sum, total and round, offset add.
// Each stage advances when it is empty or the next one advances, so a stalled
// output holds its result while earlier stages keep filling.
// Reset clears the valid bits and all configuration registers to zero.
`include "harmonic_angle_synthesizer_defines.svh"

module harmonic_angle_synthesizer import has_pkg::*; #(
	parameter int HARMONICS        = DEFAULT_HARMONICS,
	parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,   // [15:0] azimuth_phase
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,   // [26:0] hinge_angle, [31:27] zero
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int SINE_LG = $clog2(SINE_TABLE_DEPTH);

	has_cfg_t      cfg;
	has_stage_en_t stage_en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [PHASE_W-1:0]                    ph1, ph2, ph3;
	logic [2*MAX_HARMONICS-1:0][PHASE_W-1:0] phases;
	logic [2*MAX_HARMONICS-1:0][SINE_W-1:0]  sines;
	logic signed [OUT_W-1:0]               sum_s5;
	logic signed [OUT_W-1:0]               hinge_s6;

	has_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ready chain from the output back
	always_comb begin
		stage_en.s6 = !v_s6 || m_tready;
		stage_en.s5 = !v_s5 || stage_en.s6;
		stage_en.s4 = !v_s4 || stage_en.s5;
		stage_en.s3 = !v_s3 || stage_en.s4;
		stage_en.s2 = !v_s2 || stage_en.s3;
		stage_en.s1 = !v_s1 || stage_en.s2;
	end

	assign s_tready = stage_en.s1;
	assign m_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (stage_en.s1) v_s1 <= s_tvalid;
			if (stage_en.s2) v_s2 <= v_s1;
			if (stage_en.s3) v_s3 <= v_s2;
			if (stage_en.s4) v_s4 <= v_s3;
			if (stage_en.s5) v_s5 <= v_s4;
			if (stage_en.s6) v_s6 <= v_s5;
		end
	end

	// harmonic phases wrap at a full turn; cosine reads a quarter turn later
	assign ph1 = s_tdata[PHASE_W-1:0];
	assign ph2 = {ph1[PHASE_W-2:0], 1'b0};
	assign ph3 = ph1 + ph2;

	always_comb begin
		phases[0] = ph1;
		phases[1] = ph2;
		phases[2] = ph3;
		phases[3] = ph1 + QUARTER_TURN;
		phases[4] = ph2 + QUARTER_TURN;
		phases[5] = ph3 + QUARTER_TURN;
	end

	for (genvar gl = 0; gl < 2*MAX_HARMONICS; gl++) begin : g_lookup
		has_sine_lookup #(
			.SINE_LG (SINE_LG)
		) u_lookup (
			.clk      (clk),
			.stage_en (stage_en),
			.phase    (phases[gl]),
			.sine_s2  (sines[gl])
		);
	end

	has_mac #(
		.HARMONICS (HARMONICS)
	) u_mac (
		.clk      (clk),
		.stage_en (stage_en),
		.cfg      (cfg),
		.sine     (sines),
		.sum_s5   (sum_s5)
	);

	always_ff @(posedge clk) begin
		if (stage_en.s6)
			hinge_s6 <= sum_s5 + OUT_W'(cfg.neutral_position) + OUT_W'(cfg.constant_term);
	end

	assign m_tdata = {{(TDATA_OUT_W-OUT_W){1'b0}}, hinge_s6};

	`HAS_ASSERT_NOW(a_ready_only_when_full, !s_tready, v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6, "input stalled while a stage is empty")
	`HAS_ASSERT_NEXT(a_accept_enters_s1, s_tvalid && s_tready, v_s1, "accepted transaction did not enter the first stage")
	`HAS_ASSERT_NEXT(a_s5_moves_to_out, v_s5 && stage_en.s6, v_s6, "result lost between rounding and output stage")
	`HAS_ASSERT_NEXT(a_out_held_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(hinge_s6), "stalled result dropped or changed")

endmodule
